// File: src/jhtb_pkg.sv
// jhtb_pkg: shared types and constants of the huffman table builder
// used by jpeg_huffman_table_builder_core
`default_nettype none
package jhtb_pkg;
	localparam int DefMaxCodeLength = 16;
	localparam int DefNumSymbols    = 256;
	localparam int DefLookaheadBits = 8;
	localparam int SymW    = 8;
	localparam int CodeW   = 16;
	localparam int SizeW   = 5;
	localparam int MaxW    = 21;
	localparam int StatW   = 2;
	localparam int OutW    = 80;
	localparam logic [MaxW-1:0] SentinelMax = 21'h0fffff;
	localparam logic [MaxW-1:0] MaxNone     = 21'h1fffff;

	typedef enum logic [2:0] {
		REQ_LOAD_COUNT  = 3'd0,
		REQ_LOAD_SYMBOL = 3'd1,
		REQ_BUILD       = 3'd2,
		REQ_ENC_LOOKUP  = 3'd3,
		REQ_DEC_LOOKUP  = 3'd4,
		REQ_LA_LOOKUP   = 3'd5,
		REQ_BAD6        = 3'd6,
		REQ_BAD7        = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CLAMPED = 2'd1,
		ST_BAD_IDX = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_LOOK, S_LEN, S_RD, S_POS, S_LA, S_DONE
	} state_t;

	typedef struct packed {
		logic [CodeW-1:0] code;
		logic [SizeW-1:0] code_length;
		logic [CodeW-1:0] min_code;
		logic [MaxW-1:0]  max_code;
		logic [SymW-1:0]  value_pointer;
		logic [SymW-1:0]  lookahead_symbol;
		status_t          status;
	} result_t;
endpackage
`default_nettype wire

// File: src/jhtb_ram.sv
// jhtb_ram: generic single-write, single-read ram with registered read
// depends on nothing
`default_nettype none
module jhtb_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: src/jpeg_huffman_table_builder_core.sv
// jpeg_huffman_table_builder_core: canonical huffman table builder, top level
// depends on jhtb_pkg and jhtb_ram
//
// Input stream: s_tuser carries the request type, s_tdata the index and the
// data byte. Every beat gets exactly one result beat on the master side.
// Loads of a count or a symbol answer the cycle after acceptance; lookups
// answer from the S_LOOK state, which takes the registered table read into
// the result register. The ready output drops while the result register is
// full, so a stalled receiver holds the block.
// A build sweeps both the encode table and the lookahead table to zero,
// then walks every length and every symbol position: an S_LEN step per
// length, S_RD and S_POS steps per position, and an S_LA step per
// lookahead entry filled. The build sequencer has a single code counter;
// ready stays low until the build result is taken.
// After reset the same zeroing sweep runs before the first beat is taken;
// the count registers and decode tables are cleared at once by reset.
`default_nettype none
module jpeg_huffman_table_builder_core
	import jhtb_pkg::*;
#(
	parameter int MAX_CODE_LENGTH = DefMaxCodeLength,
	parameter int NUM_SYMBOLS     = DefNumSymbols,
	parameter int LOOKAHEAD_BITS  = DefLookaheadBits
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [15:0]    s_tdata, // index, data_value
	input  wire logic [2:0]     s_tuser, // req_type
	output logic                m_tvalid,
	input  wire logic           m_tready,
	// code, code_length, min_code, max_code, value_pointer,
	// lookahead_symbol, status, zero pad
	output logic [OutW-1:0]     m_tdata
);
	localparam int LaSize = 1 << LOOKAHEAD_BITS;
	localparam int LaW    = LOOKAHEAD_BITS;
	localparam int SymAw  = $clog2(NUM_SYMBOLS);
	localparam int PW     = $clog2(NUM_SYMBOLS) + 1;
	localparam int DiW    = $clog2(MAX_CODE_LENGTH);
	localparam int CW     = MAX_CODE_LENGTH + 10;
	localparam int ClrN   = (LaSize > 256) ? LaSize : 256;
	localparam int ClrW   = $clog2(ClrN);
	localparam int LaDW   = SizeW + SymW;
	localparam int EncDW  = CodeW + SizeW;

	state_t state_q, state_d;
	logic [SizeW-1:0] len_q;
	logic [PW-1:0]    p_q;
	logic [CW-1:0]    code_q;
	logic [8:0]       k_q;
	logic [LaW-1:0]   q_q, qend_q;
	logic [SymW-1:0]  sym_q;
	logic [ClrW-1:0]  clr_q;
	logic             clamp_q, build_q, sent_q;
	req_t             req_q;
	logic [7:0]       idx_q;
	logic [7:0]       cnt_q [MAX_CODE_LENGTH];
	logic [CodeW-1:0] dmin_q [MAX_CODE_LENGTH];
	logic [CodeW-1:0] dmax_q [MAX_CODE_LENGTH];
	logic [7:0]       dptr_q [MAX_CODE_LENGTH];
	logic             dval_q [MAX_CODE_LENGTH];
	logic             out_valid_q;
	result_t          out_q, res;

	req_t       in_req;
	logic [7:0] in_idx, in_dat;
	logic       accept;
	assign in_req = req_t'(s_tuser);
	assign in_idx = s_tdata[7:0];
	assign in_dat = s_tdata[15:8];
	assign accept = s_tvalid && s_tready;

	// ram ports
	logic             sym_we, enc_we, la_we;
	logic [SymAw-1:0] sym_waddr, sym_raddr;
	logic [SymW-1:0]  sym_rdata;
	logic [7:0]       enc_waddr;
	logic [EncDW-1:0] enc_wdata, enc_rdata;
	logic [LaW-1:0]   la_waddr, la_raddr;
	logic [LaDW-1:0]  la_wdata, la_rdata;

	jhtb_ram #(.Width(SymW), .Depth(NUM_SYMBOLS)) u_sym_ram (
		.clk, .we(sym_we), .waddr(sym_waddr), .wdata(in_dat),
		.raddr(sym_raddr), .rdata(sym_rdata)
	);
	jhtb_ram #(.Width(EncDW), .Depth(256)) u_enc_ram (
		.clk, .we(enc_we), .waddr(enc_waddr), .wdata(enc_wdata),
		.raddr(in_idx), .rdata(enc_rdata)
	);
	jhtb_ram #(.Width(LaDW), .Depth(LaSize)) u_la_ram (
		.clk, .we(la_we), .waddr(la_waddr), .wdata(la_wdata),
		.raddr(la_raddr), .rdata(la_rdata)
	);

	// build datapath terms
	logic [DiW-1:0]  li;
	logic [8:0]      room, cnt9, c9;
	logic            cut, fits, last_pos, last_len, la_end;
	logic [SizeW-1:0] shamt;
	logic [LaW-1:0]  lo, mask;
	logic [CW-1:0]   code_inc;

	assign li       = DiW'(len_q - 5'd1);
	assign room     = 9'(NUM_SYMBOLS) - 9'(p_q);
	assign cnt9     = {1'b0, cnt_q[li]};
	assign cut      = cnt9 > room;
	assign c9       = cut ? room : cnt9;
	assign shamt    = 5'(LOOKAHEAD_BITS) - len_q;
	assign fits     = (len_q <= 5'(LOOKAHEAD_BITS)) && ((code_q >> len_q) == '0);
	assign lo       = LaW'(code_q << shamt);
	assign mask     = ~({LaW{1'b1}} << shamt);
	assign last_pos = k_q == 9'd1;
	assign last_len = len_q == 5'(MAX_CODE_LENGTH);
	assign la_end   = q_q == qend_q;
	assign code_inc = code_q + 1'b1;

	// index checks for loads and lookups
	logic ok_cnt, ok_sym, ok_dec, ok_la;
	logic [DiW-1:0] in_li, q_li;
	assign ok_cnt = (in_idx >= 8'd1) && (in_idx <= 8'(MAX_CODE_LENGTH));
	assign ok_sym = {1'b0, in_idx} < 9'(NUM_SYMBOLS);
	assign ok_dec = (idx_q >= 8'd1) && ({1'b0, idx_q} <= 9'(MAX_CODE_LENGTH + 1));
	assign ok_la  = {3'b0, idx_q} < 11'(LaSize);
	assign in_li  = DiW'(in_idx - 8'd1);
	assign q_li   = DiW'(idx_q - 8'd1);
	assign la_raddr = LaW'({{LaW{1'b0}}, in_idx});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == ClrW'(ClrN - 1)) begin
				state_d = build_q ? S_LEN : S_IDLE;
			end
			S_IDLE: if (accept) begin
				priority case (in_req)
					REQ_BUILD: state_d = S_CLEAR;
					REQ_ENC_LOOKUP, REQ_DEC_LOOKUP, REQ_LA_LOOKUP: state_d = S_LOOK;
					default: state_d = S_IDLE;
				endcase
			end
			S_LOOK: state_d = S_IDLE;
			S_LEN: begin
				if (c9 != 9'd0) begin
					state_d = S_RD;
				end else begin
					state_d = last_len ? S_DONE : S_LEN;
				end
			end
			S_RD: state_d = S_POS;
			S_POS: begin
				if (fits) begin
					state_d = S_LA;
				end else if (last_pos) begin
					state_d = last_len ? S_DONE : S_LEN;
				end else begin
					state_d = S_RD;
				end
			end
			S_LA: begin
				if (!la_end) begin
					state_d = S_LA;
				end else if (last_pos) begin
					state_d = last_len ? S_DONE : S_LEN;
				end else begin
					state_d = S_RD;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and ram controls
	always_comb begin
		s_tready  = (state_q == S_IDLE) && !out_valid_q;
		sym_we    = accept && (in_req == REQ_LOAD_SYMBOL) && ok_sym;
		sym_waddr = SymAw'(in_idx);
		sym_raddr = SymAw'(p_q);
		enc_we    = 1'b0;
		enc_waddr = sym_rdata;
		enc_wdata = {code_q[CodeW-1:0], len_q};
		la_we     = 1'b0;
		la_waddr  = q_q;
		la_wdata  = {len_q, sym_q};
		unique case (state_q)
			S_CLEAR: begin
				enc_we    = 1'b1;
				enc_waddr = clr_q[7:0];
				enc_wdata = '0;
				la_we     = 1'b1;
				la_waddr  = clr_q[LaW-1:0];
				la_wdata  = '0;
			end
			S_POS: enc_we = 1'b1;
			S_LA:  la_we  = 1'b1;
			default: ;
		endcase
	end

	// result formation
	always_comb begin
		res = '0;
		res.status = ST_OK;
		unique case (state_q)
			S_DONE: res.status = clamp_q ? ST_CLAMPED : ST_OK;
			S_LOOK: begin
				priority case (req_q)
					REQ_ENC_LOOKUP: if (enc_rdata[SizeW-1:0] != '0) begin
						res.code        = enc_rdata[EncDW-1:SizeW];
						res.code_length = enc_rdata[SizeW-1:0];
					end
					REQ_DEC_LOOKUP: begin
						if (!ok_dec) begin
							res.status = ST_BAD_IDX;
						end else if (idx_q == 8'(MAX_CODE_LENGTH + 1)) begin
							res.max_code = sent_q ? SentinelMax : MaxNone;
						end else begin
							res.min_code      = dmin_q[q_li];
							res.value_pointer = dptr_q[q_li];
							res.max_code      = dval_q[q_li] ?
								MaxW'(dmax_q[q_li]) : MaxNone;
						end
					end
					default: begin
						if (ok_la) begin
							res.code_length      = la_rdata[LaDW-1:SymW];
							res.lookahead_symbol = la_rdata[SymW-1:0];
						end else begin
							res.status = ST_BAD_IDX;
						end
					end
				endcase
			end
			default: begin
				priority case (in_req)
					REQ_LOAD_COUNT:  res.status = ok_cnt ? ST_OK : ST_BAD_IDX;
					REQ_LOAD_SYMBOL: res.status = ok_sym ? ST_OK : ST_BAD_IDX;
					default:         res.status = ST_BAD_IDX;
				endcase
			end
		endcase
	end

	// control and table registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			build_q     <= 1'b0;
			sent_q      <= 1'b0;
			clamp_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			req_q       <= REQ_LOAD_COUNT;
			idx_q       <= '0;
			len_q       <= '0;
			p_q         <= '0;
			k_q         <= '0;
			code_q      <= '0;
			q_q         <= '0;
			qend_q      <= '0;
			sym_q       <= '0;
			for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
				cnt_q[i]  <= '0;
				dmin_q[i] <= '0;
				dmax_q[i] <= '0;
				dptr_q[i] <= '0;
				dval_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q  <= clr_q + 1'b1;
					len_q  <= 5'd1;
					p_q    <= '0;
					code_q <= '0;
				end
				S_IDLE: if (accept) begin
					req_q <= in_req;
					idx_q <= in_idx;
					clr_q <= '0;
					priority case (in_req)
						REQ_LOAD_COUNT: begin
							if (ok_cnt) begin
								cnt_q[in_li] <= in_dat;
							end
							out_valid_q <= 1'b1;
							out_q       <= res;
						end
						REQ_LOAD_SYMBOL: begin
							out_valid_q <= 1'b1;
							out_q       <= res;
						end
						REQ_BUILD: begin
							build_q <= 1'b1;
							clamp_q <= 1'b0;
						end
						REQ_ENC_LOOKUP, REQ_DEC_LOOKUP, REQ_LA_LOOKUP: ;
						default: begin
							out_valid_q <= 1'b1;
							out_q       <= res;
						end
					endcase
				end
				S_LOOK: begin
					out_valid_q <= 1'b1;
					out_q       <= res;
				end
				S_LEN: begin
					if (cut) begin
						clamp_q <= 1'b1;
					end
					if (c9 == 9'd0) begin
						dmin_q[li] <= '0;
						dptr_q[li] <= '0;
						dval_q[li] <= 1'b0;
						code_q     <= code_q << 1;
						len_q      <= len_q + 1'b1;
					end else begin
						dmin_q[li] <= code_q[CodeW-1:0];
						dptr_q[li] <= 8'(p_q);
						k_q        <= c9;
					end
				end
				S_RD: ;
				S_POS, S_LA: begin
					if (state_q == S_POS) begin
						sym_q  <= sym_rdata;
						q_q    <= lo;
						qend_q <= lo | mask;
					end else begin
						q_q <= q_q + 1'b1;
					end
					// step to the next position once its lookahead run is done, or at once if the code does not fit
					if ((state_q == S_POS && !fits) || (state_q == S_LA && la_end)) begin
						p_q <= p_q + 1'b1;
						k_q <= k_q - 1'b1;
						if (last_pos) begin
							dval_q[li] <= 1'b1;
							dmax_q[li] <= code_q[CodeW-1:0];
							code_q     <= code_inc << 1;
							len_q      <= len_q + 1'b1;
						end else begin
							code_q <= code_inc;
						end
					end
				end
				S_DONE: begin
					sent_q      <= 1'b1;
					build_q     <= 1'b0;
					out_valid_q <= 1'b1;
					out_q       <= res;
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OutW - $bits(result_t)){1'b0}},
		out_q.status, out_q.lookahead_symbol, out_q.value_pointer,
		out_q.max_code, out_q.min_code, out_q.code_length, out_q.code};

	// a new beat is only taken with the result register empty
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("ready with result pending");
	// a build always starts with the zeroing sweep
	a_build_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_req == REQ_BUILD) |=> (state_q == S_CLEAR))
		else $error("build did not start sweep");
	// the sequencer never holds ready while it walks the tables
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready) else $error("ready while busy");
	// reserved status code never leaves the block
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.status != ST_RSVD)) else $error("bad status");
endmodule
`default_nettype wire
